// File: rtl/core/cconv_pkg.sv
// ----------------------------------------------------------------------------
// cconv_pkg
// Shared types and constants of the complex int16 full convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package cconv_pkg;

  localparam int MAX_LEN = 32;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = 6;
  localparam int DATA_W  = 16;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             wr;
    logic             ld_out;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] j0;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] k;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic calc_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/cconv_ctrl.sv
// ----------------------------------------------------------------------------
// cconv_ctrl
// Sequence controller: tracks element count and tail drain, issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cconv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic              in_seq_last,
  input  wire cconv_pkg::status_t status,
  output cconv_pkg::cmd_t        cmd
);

  cconv_pkg::state_t                state_r, state_nxt;
  logic [cconv_pkg::CNT_W-1:0]      elem_count_r, elem_count_nxt;
  logic                             draining_r, draining_nxt;
  logic [cconv_pkg::CNT_W-1:0]      next_out_r, next_out_nxt;

  logic                             accept;
  logic                             push_ok;
  logic                             drain_ok;
  logic [cconv_pkg::CNT_W:0]        n2;
  logic [cconv_pkg::CNT_W:0]        d_cnt;
  logic                             d_last;
  logic [cconv_pkg::CNT_W-1:0]      n_m1;
  logic [cconv_pkg::CNT_W-1:0]      d_lo;
  logic [cconv_pkg::CNT_W-1:0]      p_cnt;

  assign accept   = in_valid & in_ready;
  assign push_ok  = (in_req_type == cconv_pkg::REQ_PUSH) && !draining_r &&
                    (elem_count_r < cconv_pkg::CNT_W'(cconv_pkg::MAX_LEN));
  assign drain_ok = (in_req_type == cconv_pkg::REQ_DRAIN) && draining_r;

  assign n2     = {elem_count_r, 1'b0};
  assign n_m1   = elem_count_r - 1'b1;
  assign d_lo   = next_out_r - n_m1;
  assign d_cnt  = n2 - 1'b1 - {1'b0, next_out_r};
  assign d_last = ({1'b0, next_out_r} == (n2 - 2'd2));
  assign p_cnt  = elem_count_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cconv_pkg::ST_IDLE: begin
        if (accept && (push_ok || drain_ok)) state_nxt = cconv_pkg::ST_CALC;
      end
      cconv_pkg::ST_CALC: begin
        if (status.calc_done) begin
          state_nxt = status.out_free ? cconv_pkg::ST_IDLE : cconv_pkg::ST_WAIT;
        end
      end
      cconv_pkg::ST_WAIT: begin
        if (status.out_free) state_nxt = cconv_pkg::ST_IDLE;
      end
      default: state_nxt = cconv_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.wr_idx = elem_count_r[cconv_pkg::IDX_W-1:0];
    case (state_r)
      cconv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && push_ok) begin
          cmd.start = 1'b1;
          cmd.wr    = 1'b1;
          cmd.i0    = '0;
          cmd.j0    = elem_count_r[cconv_pkg::IDX_W-1:0];
          cmd.cnt   = p_cnt;
          cmd.k     = elem_count_r;
          cmd.last  = in_seq_last && (elem_count_r == '0);
        end else if (in_valid && drain_ok) begin
          cmd.start = 1'b1;
          cmd.i0    = d_lo[cconv_pkg::IDX_W-1:0];
          cmd.j0    = n_m1[cconv_pkg::IDX_W-1:0];
          cmd.cnt   = d_cnt[cconv_pkg::CNT_W-1:0];
          cmd.k     = next_out_r;
          cmd.last  = d_last;
        end
      end
      cconv_pkg::ST_CALC: begin
        cmd.ld_out = status.calc_done & status.out_free;
      end
      cconv_pkg::ST_WAIT: begin
        cmd.ld_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // sequence bookkeeping
  always_comb begin
    elem_count_nxt = elem_count_r;
    draining_nxt   = draining_r;
    next_out_nxt   = next_out_r;
    if (accept && push_ok) begin
      elem_count_nxt = p_cnt;
      if (in_seq_last) begin
        if (elem_count_r == '0) begin
          elem_count_nxt = '0;
        end else begin
          draining_nxt = 1'b1;
          next_out_nxt = p_cnt;
        end
      end
    end else if (accept && drain_ok) begin
      if (d_last) begin
        elem_count_nxt = '0;
        draining_nxt   = 1'b0;
        next_out_nxt   = '0;
      end else begin
        next_out_nxt = next_out_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cconv_pkg::ST_IDLE;
      elem_count_r <= '0;
      draining_r   <= 1'b0;
      next_out_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      elem_count_r <= elem_count_nxt;
      draining_r   <= draining_nxt;
      next_out_r   <= next_out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cconv_dp.sv
// ----------------------------------------------------------------------------
// cconv_dp
// Element stores, shared complex multiply-accumulate and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cconv_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cconv_pkg::cmd_t               cmd,
  output cconv_pkg::status_t                 status,
  input  wire logic [cconv_pkg::DATA_W-1:0]  a_re,
  input  wire logic [cconv_pkg::DATA_W-1:0]  a_im,
  input  wire logic [cconv_pkg::DATA_W-1:0]  b_re,
  input  wire logic [cconv_pkg::DATA_W-1:0]  b_im,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cconv_pkg::DATA_W-1:0]       y_re,
  output logic [cconv_pkg::DATA_W-1:0]       y_im,
  output logic [cconv_pkg::CNT_W-1:0]        y_index,
  output logic                               y_last
);

  localparam int DW = cconv_pkg::DATA_W;

  logic [2*DW-1:0]             mem_a [cconv_pkg::MAX_LEN];
  logic [2*DW-1:0]             mem_b [cconv_pkg::MAX_LEN];

  logic [cconv_pkg::IDX_W-1:0] i_r, j_r;
  logic [cconv_pkg::CNT_W-1:0] cnt_r;
  logic [cconv_pkg::CNT_W-1:0] k_r;
  logic                        last_r;
  logic                        issue;

  logic [2*DW-1:0]             rd_a_r, rd_b_r;
  logic                        rd_v_r;
  logic [DW-1:0]               p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                        mul_v_r;
  logic [DW-1:0]               acc_re_r, acc_im_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [DW-1:0]               y_re_r, y_im_r;
  logic [cconv_pkg::CNT_W-1:0] y_index_r;
  logic                        y_last_r;

  assign issue = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_a[cmd.wr_idx] <= {a_im, a_re};
      mem_b[cmd.wr_idx] <= {b_im, b_re};
    end
    if (issue) begin
      rd_a_r <= mem_a[i_r];
      rd_b_r <= mem_b[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt_r <= cmd.cnt;
      end else if (issue) begin
        cnt_r <= cnt_r - 1'b1;
      end
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_r      <= cmd.i0;
      j_r      <= cmd.j0;
      k_r      <= cmd.k;
      last_r   <= cmd.last;
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else begin
      if (issue) begin
        i_r <= i_r + 1'b1;
        j_r <= j_r - 1'b1;
      end
      if (mul_v_r) begin
        acc_re_r <= acc_re_r + p_rr_r - p_ii_r;
        acc_im_r <= acc_im_r + p_ri_r + p_ir_r;
      end
    end
    if (rd_v_r) begin
      p_rr_r <= rd_a_r[DW-1:0]    * rd_b_r[DW-1:0];
      p_ii_r <= rd_a_r[2*DW-1:DW] * rd_b_r[2*DW-1:DW];
      p_ri_r <= rd_a_r[DW-1:0]    * rd_b_r[2*DW-1:DW];
      p_ir_r <= rd_a_r[2*DW-1:DW] * rd_b_r[DW-1:0];
    end
  end

  assign status.calc_done = !issue && !rd_v_r && !mul_v_r;
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      y_re_r    <= acc_re_r;
      y_im_r    <= acc_im_r;
      y_index_r <= k_r;
      y_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign y_re      = y_re_r;
  assign y_im      = y_im_r;
  assign y_index   = y_index_r;
  assign y_last    = y_last_r;

endmodule

`default_nettype wire

// File: rtl/core/complex_int16_full_convolution.sv
// Each item with t product terms (t = k+1 for a push of element k,
// t = 2n-1-k for tail output k) is computed by the single shared complex
// multiply-accumulate unit, one product per cycle. A new item is taken only
// once the last result is in the output register; items with no result
// are taken while idle and start no job. Reset is synchronous, active low;
// it clears control state, element stores hold no reset value.
// ----------------------------------------------------------------------------
// complex_int16_full_convolution
// Full linear convolution of two complex int16 sequences, 16-bit wrapping.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_int16_full_convolution (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic signed [15:0]   in_a_re,
  input  wire logic signed [15:0]   in_a_im,
  input  wire logic signed [15:0]   in_b_re,
  input  wire logic signed [15:0]   in_b_im,
  input  wire logic                 in_seq_last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        out_y_re,
  output logic signed [15:0]        out_y_im,
  output logic [5:0]                out_y_index,
  output logic                      out_y_last
);

  cconv_pkg::cmd_t    cmd;
  cconv_pkg::status_t status;

  cconv_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_seq_last (in_seq_last),
    .status      (status),
    .cmd         (cmd)
  );

  cconv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .a_re      (in_a_re),
    .a_im      (in_a_im),
    .b_re      (in_b_re),
    .b_im      (in_b_im),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .y_re      (out_y_re),
    .y_im      (out_y_im),
    .y_index   (out_y_index),
    .y_last    (out_y_last)
  );

endmodule

`default_nettype wire

// File: tb/cconv_checker.sv
// ----------------------------------------------------------------------------
// cconv_checker
// Watches both channels of the complex int16 convolution block. Keeps its
// own copy of the element stores and the sequence control, predicts every
// result of an accepted input transaction and compares each accepted output
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cconv_checker
  import cconv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_a_re,
  input  wire logic signed [15:0] in_a_im,
  input  wire logic signed [15:0] in_b_re,
  input  wire logic signed [15:0] in_b_im,
  input  wire logic               in_seq_last,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] out_y_re,
  input  wire logic signed [15:0] out_y_im,
  input  wire logic [5:0]         out_y_index,
  input  wire logic               out_y_last,
  output int                      n_errors,
  output int                      n_pending
);

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic [5:0]  idx;
    logic        last;
  } conv_out_t;

  logic [31:0] a_mem [MAX_LEN];
  logic [31:0] b_mem [MAX_LEN];
  int unsigned elem_cnt;
  int unsigned tail_idx;
  bit          tail_open;
  conv_out_t   conv_out_q [$];

  // y_k = sum of a_i * b_(k-i) over stored elements, 16-bit wrap throughout
  function automatic conv_out_t conv_point(int unsigned k, int unsigned n, logic last);
    logic [15:0] sr;
    logic [15:0] si;
    logic [15:0] ar, ai, br, bi;
    int unsigned lo;
    conv_out_t   r;
    sr = '0;
    si = '0;
    lo = (k >= n) ? k - (n - 1) : 0;
    for (int unsigned i = lo; i <= k && i < n; i++) begin
      ar = a_mem[i][15:0];
      ai = a_mem[i][31:16];
      br = b_mem[k-i][15:0];
      bi = b_mem[k-i][31:16];
      sr = sr + ar * br - ai * bi;
      si = si + ar * bi + ai * br;
    end
    r.re   = sr;
    r.im   = si;
    r.idx  = 6'(k);
    r.last = last;
    return r;
  endfunction

  task automatic close_sequence();
    elem_cnt  = 0;
    tail_open = 1'b0;
    tail_idx  = 0;
  endtask

  task automatic predict_request(logic req, logic [15:0] ar, logic [15:0] ai,
                                 logic [15:0] br, logic [15:0] bi, logic sl);
    int unsigned k;
    logic        last;
    if (req == REQ_PUSH) begin
      if (!tail_open && elem_cnt < MAX_LEN) begin
        k = elem_cnt;
        a_mem[k] = {ai, ar};
        b_mem[k] = {bi, br};
        elem_cnt = k + 1;
        if (sl && elem_cnt == 1) begin
          conv_out_q.push_back(conv_point(k, elem_cnt, 1'b1));
          close_sequence();
        end else begin
          conv_out_q.push_back(conv_point(k, elem_cnt, 1'b0));
          if (sl) begin
            tail_open = 1'b1;
            tail_idx  = elem_cnt;
          end
        end
      end
    end else if (tail_open) begin
      k    = tail_idx;
      last = (k >= 2 * elem_cnt - 2);
      conv_out_q.push_back(conv_point(k, elem_cnt, last));
      if (last) begin
        close_sequence();
      end else begin
        tail_idx = k + 1;
      end
    end
  endtask

  task automatic report(string field, logic [15:0] exp_v, logic [15:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    n_errors++;
  endtask

  always @(posedge clk) begin : watch
    conv_out_t got;
    conv_out_t want;
    if (!rst_n) begin
      close_sequence();
      conv_out_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_req_type, in_a_re, in_a_im, in_b_re, in_b_im, in_seq_last);
      end
      if (out_valid && out_ready) begin
        got = '{re: out_y_re, im: out_y_im, idx: out_y_index, last: out_y_last};
        if (conv_out_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual re %h im %h idx %0d last %0b",
                   $time, got.re, got.im, got.idx, got.last);
          n_errors++;
        end else begin
          want = conv_out_q.pop_front();
          if (got.re !== want.re) report("y_re", want.re, got.re);
          if (got.im !== want.im) report("y_im", want.im, got.im);
          if (got.idx !== want.idx) report("y_index", 16'(want.idx), 16'(got.idx));
          if (got.last !== want.last) report("y_last", 16'(want.last), 16'(got.last));
        end
      end
    end
    n_pending <= conv_out_q.size();
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives push and drain requests into the convolution block: directed corner
// cases first, then random sequences of mixed length with some broken ones,
// then an overfull sequence. Output stalls, a long receiver hold-off and a
// full drain pause are mixed in. The checker reports mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cconv_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_req_type = REQ_PUSH;
  logic signed [15:0] in_a_re     = '0;
  logic signed [15:0] in_a_im     = '0;
  logic signed [15:0] in_b_re     = '0;
  logic signed [15:0] in_b_im     = '0;
  logic               in_seq_last = 1'b0;
  logic               out_ready   = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire signed [15:0]  out_y_re;
  wire signed [15:0]  out_y_im;
  wire [5:0]          out_y_index;
  wire                out_y_last;

  int n_errors;
  int n_pending;
  int n_sent;
  int idle_cycles;
  bit quiet       = 1'b0;
  bit rx_hold_req = 1'b0;
  bit hold_done   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_int16_full_convolution u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .in_seq_last (in_seq_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_y_re    (out_y_re),
    .out_y_im    (out_y_im),
    .out_y_index (out_y_index),
    .out_y_last  (out_y_last)
  );

  cconv_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .in_seq_last (in_seq_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_y_re    (out_y_re),
    .out_y_im    (out_y_im),
    .out_y_index (out_y_index),
    .out_y_last  (out_y_last),
    .n_errors    (n_errors),
    .n_pending   (n_pending)
  );

  function automatic logic [15:0] rand16();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Returns at the edge where the transaction is taken; valid stays high.
  task automatic send(logic req, logic [15:0] ar, logic [15:0] ai,
                      logic [15:0] br, logic [15:0] bi, logic sl);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_a_re     <= ar;
    in_a_im     <= ai;
    in_b_re     <= br;
    in_b_im     <= bi;
    in_seq_last <= sl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic push_rand(logic sl);
    send(REQ_PUSH, rand16(), rand16(), rand16(), rand16(), sl);
  endtask

  task automatic drain_rand();
    send(REQ_DRAIN, rand16(), rand16(), rand16(), rand16(), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic run_sequence(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && i == n - 1 && $urandom_range(2) == 0) drain_rand();
      push_rand(i == n - 1);
      n_sent++;
    end
    for (int k = 0; k < 2 * n - 2; k++) begin
      if (noisy && $urandom_range(7) == 0) push_rand(1'($urandom_range(1)));
      drain_rand();
      n_sent++;
    end
    if (noisy && $urandom_range(2) == 0) drain_rand();
  endtask

  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int r;
    int n;
    n_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    drain_rand();
    send(REQ_PUSH, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send(REQ_PUSH, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send(REQ_PUSH, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 1'b1);
    send(REQ_PUSH, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send(REQ_PUSH, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    drain_rand();
    send(REQ_PUSH, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 1'b1);
    push_rand(1'b1);
    drain_rand();
    drain_rand();
    drain_rand();
    wait_drained();

    // random sequences
    while (n_sent < 950) begin
      quiet = (n_sent >= 300 && n_sent < 500);
      if (!hold_done && n_sent >= 700) begin
        rx_hold_req = 1'b1;
        hold_done   = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(1, 6);
      else if (r < 92) n = $urandom_range(7, 16);
      else if (r < 96) n = MAX_LEN;
      else             n = $urandom_range(17, MAX_LEN - 1);
      run_sequence(n, $urandom_range(3) == 0);
      if ($urandom_range(19) == 0) wait_drained();
    end
    quiet = 1'b0;
    run_sequence(MAX_LEN, 1'b0);

    // overfull sequence: stays open for the rest of the run
    for (int i = 0; i < MAX_LEN; i++) push_rand(1'b0);
    push_rand(1'b1);
    drain_rand();

    wait_drained();
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
